// ----- rtl/cal_pkg.sv -----
package cal_pkg;

	// Time limits
	localparam logic [5:0] SEC_MAX     = 6'd59;
	localparam logic [5:0] MIN_MAX     = 6'd59;
	localparam logic [4:0] HOUR_MAX    = 5'd23;
	localparam logic [5:0] SOUND_LIMIT = 6'd40;

	// Log pointer width default and fixed width of the log address field
	localparam int LOG_ADDR_BITS_DEF = 12;
	localparam int LOG_OUT_W         = 12;

	// Config port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic {
		REG_ALARM_HOUR   = 1'b0,
		REG_ALARM_MINUTE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_SILENCE = 2'd1,
		OP_SET     = 2'd2,
		OP_ARM     = 2'd3
	} op_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
	} alarm_cfg_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] set_hour;
		logic [5:0] set_minute;
		logic [9:0] temperature_sample;
	} item_t;

	typedef struct packed {
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic       armed;
		logic       sounding;
		logic [5:0] sound_minutes;
	} clk_state_t;

	typedef struct packed {
		logic [4:0]           hour_now;
		logic [5:0]           minute_now;
		logic [5:0]           second_now;
		logic                 alarm_sounding;
		logic                 alarm_is_armed;
		logic                 log_valid;
		logic [LOG_OUT_W-1:0] log_address;
		logic [4:0]           log_hour;
		logic [7:0]           log_temperature;
	} result_t;

endpackage

// ----- rtl/cal_apb_regs.sv -----
module cal_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cal_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [cal_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [cal_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output cal_pkg::alarm_cfg_t             cfg
);
	import cal_pkg::*;

	alarm_cfg_t cfg_q;
	reg_idx_t   idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ALARM_HOUR:   cfg_q.hour   <= pwdata[4:0];
				REG_ALARM_MINUTE: cfg_q.minute <= pwdata[5:0];
				default:          cfg_q        <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ALARM_HOUR:   prdata = APB_DATA_W'(cfg_q.hour);
			REG_ALARM_MINUTE: prdata = APB_DATA_W'(cfg_q.minute);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/cal_step.sv -----
module cal_step #(
	parameter int LOG_ADDR_BITS = cal_pkg::LOG_ADDR_BITS_DEF
) (
	input  cal_pkg::clk_state_t       cur,
	input  logic [LOG_ADDR_BITS-1:0]  cur_ptr,
	input  cal_pkg::item_t            item,
	input  cal_pkg::alarm_cfg_t       cfg,
	output cal_pkg::clk_state_t       nxt,
	output logic [LOG_ADDR_BITS-1:0]  nxt_ptr,
	output cal_pkg::result_t          res
);
	import cal_pkg::*;

	logic [5:0] snd_cnt;

	always_comb begin
		nxt     = cur;
		nxt_ptr = cur_ptr;
		snd_cnt = 6'(cur.sound_minutes + 6'd1);
		res     = '0;

		case (item.op)
			OP_TICK: begin
				if (cur.seconds >= SEC_MAX) begin
					nxt.seconds = '0;
					if (cur.minutes >= MIN_MAX) begin
						nxt.minutes = '0;
						nxt.hours   = (cur.hours >= HOUR_MAX) ? 5'd0 : 5'(cur.hours + 5'd1);
						// hourly record: hour byte at pointer, temperature at pointer+1
						res.log_valid       = 1'b1;
						res.log_address     = LOG_OUT_W'(cur_ptr);
						res.log_hour        = nxt.hours;
						res.log_temperature = item.temperature_sample[8:1];
						nxt_ptr             = LOG_ADDR_BITS'(cur_ptr + LOG_ADDR_BITS'(2));
					end else begin
						nxt.minutes = 6'(cur.minutes + 6'd1);
					end
					if (cur.sounding) begin
						if (snd_cnt >= SOUND_LIMIT) begin
							nxt.sounding      = 1'b0;
							nxt.armed         = 1'b0;
							nxt.sound_minutes = '0;
						end else begin
							nxt.sound_minutes = snd_cnt;
						end
					end
				end else begin
					nxt.seconds = 6'(cur.seconds + 6'd1);
				end
				if (nxt.armed && nxt.hours == cfg.hour && nxt.minutes == cfg.minute)
					nxt.sounding = 1'b1;
			end
			OP_SILENCE: begin
				nxt.sounding      = 1'b0;
				nxt.armed         = 1'b0;
				nxt.sound_minutes = '0;
			end
			OP_SET: begin
				nxt.hours   = (item.set_hour > HOUR_MAX) ? HOUR_MAX : item.set_hour;
				nxt.minutes = (item.set_minute > MIN_MAX) ? MIN_MAX : item.set_minute;
			end
			OP_ARM: begin
				nxt.armed = 1'b1;
			end
			default: begin
				nxt = cur;
			end
		endcase

		res.hour_now       = nxt.hours;
		res.minute_now     = nxt.minutes;
		res.second_now     = nxt.seconds;
		res.alarm_sounding = nxt.sounding;
		res.alarm_is_armed = nxt.armed;
	end

endmodule

// ----- rtl/clock_alarm_with_hourly_log_top.sv -----
// Result path: an accepted item goes into the input register, then into the result
//   register once that register is empty or being taken by the receiver.
// Throughput: 1 item per cycle while result_stall is low; clock state is updated as each
//   item leaves the input register, so the next item in that register sees it.
// Reset (arst_n low, async): time, alarm flags, sound count, log pointer, alarm
//   registers and both valid flags clear to zero.
module clock_alarm_with_hourly_log_top #(
	parameter int LOG_ADDR_BITS = cal_pkg::LOG_ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     op,
	input  logic [4:0]                     set_hour,
	input  logic [5:0]                     set_minute,
	input  logic [9:0]                     temperature_sample,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [4:0]                     hour_now,
	output logic [5:0]                     minute_now,
	output logic [5:0]                     second_now,
	output logic                           alarm_sounding,
	output logic                           alarm_is_armed,
	output logic                           log_valid,
	output logic [cal_pkg::LOG_OUT_W-1:0]  log_address,
	output logic [4:0]                     log_hour,
	output logic [7:0]                     log_temperature,
	// config port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cal_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cal_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cal_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import cal_pkg::*;

	alarm_cfg_t cfg;

	// stage 1: registered item
	logic  valid_s1;
	item_t item_s1;

	// clock state
	clk_state_t               st_q;
	logic [LOG_ADDR_BITS-1:0] ptr_q;

	// next-state logic outputs
	clk_state_t               st_nxt;
	logic [LOG_ADDR_BITS-1:0] ptr_nxt;
	result_t                  res_nxt;

	// stage 2: result register
	logic    valid_s2;
	result_t res_s2;

	logic accept;
	logic advance;

	// the item in stage 1 moves on when the result register is empty or being taken
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	cal_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cal_step #(
		.LOG_ADDR_BITS (LOG_ADDR_BITS)
	) u_step (
		.cur     (st_q),
		.cur_ptr (ptr_q),
		.item    (item_s1),
		.cfg     (cfg),
		.nxt     (st_nxt),
		.nxt_ptr (ptr_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{op: op_t'(op), set_hour: set_hour, set_minute: set_minute,
				temperature_sample: temperature_sample};
		end
	end

	// clock state commits as the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			ptr_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				st_q  <= st_nxt;
				ptr_q <= ptr_nxt;
			end
			valid_s2 <= advance || (valid_s2 && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid    = valid_s2;
	assign hour_now        = res_s2.hour_now;
	assign minute_now      = res_s2.minute_now;
	assign second_now      = res_s2.second_now;
	assign alarm_sounding  = res_s2.alarm_sounding;
	assign alarm_is_armed  = res_s2.alarm_is_armed;
	assign log_valid       = res_s2.log_valid;
	assign log_address     = res_s2.log_address;
	assign log_hour        = res_s2.log_hour;
	assign log_temperature = res_s2.log_temperature;

endmodule

// ----- rtl/cal_checker.sv -----
module cal_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [4:0] hour_now,
	input logic [5:0] minute_now,
	input logic [5:0] second_now,
	input logic       alarm_sounding,
	input logic       alarm_is_armed,
	input logic       log_valid,
	input logic [11:0] log_address,
	input logic [4:0] log_hour,
	input logic [7:0] log_temperature
);

	// a held result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// sounding implies armed
	a_snd_armed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && alarm_sounding |-> alarm_is_armed)
		else $error("alarm sounding while disarmed");

	// a log record only at the top of the hour
	a_log_time: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && log_valid |-> minute_now == 6'd0 && second_now == 6'd0)
		else $error("log record off the hour");

	// log fields zero without a record
	a_log_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !log_valid |->
			log_address == 12'd0 && log_hour == 5'd0 && log_temperature == 8'd0)
		else $error("log fields set without a record");

	// time in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> hour_now <= 5'd23 && minute_now <= 6'd59 && second_now <= 6'd59)
		else $error("time out of range");

endmodule

bind clock_alarm_with_hourly_log_top cal_checker u_cal_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.hour_now        (hour_now),
	.minute_now      (minute_now),
	.second_now      (second_now),
	.alarm_sounding  (alarm_sounding),
	.alarm_is_armed  (alarm_is_armed),
	.log_valid       (log_valid),
	.log_address     (log_address),
	.log_hour        (log_hour),
	.log_temperature (log_temperature)
);
